>>> rtl/dsv_pkg.sv
// Package for the date string validator: parse state and result types,
// character codes and calendar constants.
// No dependencies.
`default_nettype none

package dsv_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned DAY_W      = 7;
  localparam int unsigned MONTH_W    = 7;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned YEAR_DIGITS = 4;
  localparam int unsigned LEN_W      = 5;

  localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
  localparam logic [CH_W-1:0] CH_SLASH = 8'd47;

  localparam logic [COUNT_W-1:0] SHORT_MAX = 3'd2;
  localparam logic [COUNT_W-1:0] YEAR_MAX  = 3'd4;

  localparam logic [YEAR_W-1:0] YEAR_SHORT_LO = 14'd10;
  localparam logic [YEAR_W-1:0] YEAR_SHORT_HI = 14'd100;
  localparam logic [YEAR_W-1:0] YEAR_BASE     = 14'd2000;

  localparam logic [LEN_W-1:0] LEN_LONG  = 5'd31;
  localparam logic [LEN_W-1:0] LEN_SHORT = 5'd30;
  localparam logic [LEN_W-1:0] LEN_LEAP  = 5'd29;
  localparam logic [LEN_W-1:0] LEN_FEB   = 5'd28;
  localparam logic [LEN_W-1:0] LEN_NONE  = 5'd0;

  typedef enum logic [1:0] {
    PH_DAY   = 2'd0,
    PH_MONTH = 2'd1,
    PH_YEAR  = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t                          phase;
    logic [COUNT_W-1:0]              count;
    logic [DAY_W-1:0]                day;
    logic [MONTH_W-1:0]              month;
    logic [YEAR_W-1:0]               year;
    logic [YEAR_DIGITS-1:0][3:0]     yd;
    logic                            err;
  } parse_state_t;

  typedef struct packed {
    logic                 valid_res;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
  } result_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase: PH_DAY, count: '0, day: '0, month: '0, year: '0, yd: '0, err: 1'b0
  };

endpackage

`default_nettype wire

>>> rtl/dsv_step.sv
// Per-character update of the date parse state.
// Depends on dsv_pkg.
`default_nettype none

module dsv_step import dsv_pkg::*; (
  input  parse_state_t    st,
  input  logic [CH_W-1:0] ch,
  output parse_state_t    st_next
);

  logic       digit;
  logic [3:0] d;

  assign digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign d     = ch[3:0];

  always_comb begin
    st_next = st;
    unique case (st.phase)
      PH_DAY, PH_MONTH: begin
        if (digit) begin
          if (st.count >= SHORT_MAX) begin
            st_next.err = 1'b1;
          end else begin
            st_next.count = st.count + 3'd1;
            if (st.phase == PH_DAY) begin
              st_next.day = 7'(st.day * 7'd10) + 7'(d);
            end else begin
              st_next.month = 7'(st.month * 7'd10) + 7'(d);
            end
          end
        end else if (ch == CH_SLASH) begin
          if (st.count == '0) begin
            st_next.err = 1'b1;
          end
          st_next.phase = (st.phase == PH_DAY) ? PH_MONTH : PH_YEAR;
          st_next.count = '0;
        end else begin
          st_next.err = 1'b1;
        end
      end
      PH_YEAR: begin
        if (digit && (st.count < YEAR_MAX)) begin
          st_next.count = st.count + 3'd1;
          st_next.year  = 14'(st.year * 14'd10) + 14'(d);
          st_next.yd    = {st.yd[YEAR_DIGITS-2:0], d};
        end else begin
          st_next.err = 1'b1;
        end
      end
      default: begin
        st_next.err = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dsv_verdict.sv
// Final date check: form, year adjust, leap rule and month length.
// Depends on dsv_pkg.
`default_nettype none

module dsv_verdict import dsv_pkg::*; (
  input  parse_state_t st,
  output result_t      res
);

  logic               form_ok;
  logic               date_ok;
  logic [YEAR_W-1:0]  year_adj;
  logic [1:0]         tens_mod;
  logic [1:0]         cent_mod;
  logic               leap;
  logic [LEN_W-1:0]   len;

  assign form_ok = !st.err && (st.phase == PH_YEAR) &&
                   ((st.count == SHORT_MAX) || (st.count == YEAR_MAX));

  assign year_adj = ((st.year >= YEAR_SHORT_LO) && (st.year < YEAR_SHORT_HI)) ?
                    st.year + YEAR_BASE : st.year;

  // mod 4 of a two-digit decimal: 2 * tens + ones
  assign tens_mod = {st.yd[1][0], 1'b0} + st.yd[0][1:0];
  assign cent_mod = {st.yd[3][0], 1'b0} + st.yd[2][1:0];
  assign leap = (tens_mod == 2'd0) &&
                ((st.yd[1] != 4'd0) || (st.yd[0] != 4'd0) || (cent_mod == 2'd0));

  always_comb begin
    case (st.month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = LEN_LONG;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = LEN_SHORT;
      7'd2:                                       len = leap ? LEN_LEAP : LEN_FEB;
      default:                                    len = LEN_NONE;
    endcase
  end

  assign date_ok = form_ok && (st.day != '0) && (st.day <= 7'(len));

  assign res.valid_res = date_ok;
  assign res.day       = date_ok ? st.day   : '0;
  assign res.month     = date_ok ? st.month : '0;
  assign res.year      = date_ok ? year_adj : '0;

endmodule

`default_nettype wire

>>> rtl/date_string_validator_top.sv
// Date string validator, d/m/y form, one ASCII character per word.
// Depends on dsv_pkg, dsv_step and dsv_verdict.
//
// One character is taken every cycle unless a final character waits for a
// busy result register. A word enters an input register and from there
// updates the parse state; on the word with tlast the verdict is written to
// the result register at that same edge and the parse state is cleared. The
// result register decouples the sides: characters keep flowing while a verdict
// waits, and only a second final character stalls behind it.
`default_nettype none

module date_string_validator_top import dsv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch[7:0]
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // valid_res[0], day[7:1], month[14:8], year[28:15], zero
);

  logic            in_valid;
  logic [CH_W-1:0] in_ch;
  logic            in_last;
  logic            out_free;
  logic            adv;

  parse_state_t st;
  parse_state_t st_next;
  result_t      res_next;
  result_t      res;

  assign out_free = !m_tvalid || m_tready;
  assign adv      = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ch   <= s_tdata;
      in_last <= s_tlast;
    end
  end

  dsv_step u_step (
    .st      (st),
    .ch      (in_ch),
    .st_next (st_next)
  );

  dsv_verdict u_verdict (
    .st  (st_next),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (adv) begin
      st <= in_last ? STATE_CLEAR : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last) begin
      res <= res_next;
    end
  end

  assign m_tdata = {3'b000, res.year, res.month, res.day, res.valid_res};

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && in_last && m_tvalid && !m_tready))
    else $error("input stalled without a pending verdict");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (adv && in_last) |=> m_tvalid)
    else $error("final character produced no result");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (adv && in_last) |=> (st.phase == PH_DAY && st.count == '0 && !st.err))
    else $error("parse state not cleared after final character");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    st.count <= YEAR_MAX)
    else $error("digit count out of range");
`endif

endmodule

`default_nettype wire
